@@ sv/ttlc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttlc_pkg: shared types and constants for the line capture block
// Request and result payloads, the configuration bundle, request classes,
// status codes and the effective token length function.
// ----------------------------------------------------------------------------
package ttlc_pkg;

    // Largest number of terminator bytes that can be matched.
    localparam int TOKEN_MAX = 8;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Request type codes as they arrive on the input channel.
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_DISCARD = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_BYTES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_CLEAR    = 3'd3;

    // Configuration reset values.
    localparam logic [63:0] RST_TOKEN_BYTES   = 64'd2570;
    localparam logic [3:0]  RST_TOKEN_LENGTH  = 4'd2;
    localparam logic [8:0]  RST_LINE_CAPACITY = 9'd256;
    localparam logic        RST_NULL_CLEAR    = 1'b0;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_NULL_DROP  = 3'd1,
        ST_TOKEN_DONE = 3'd2,
        ST_REFUSED    = 3'd3,
        ST_READ_REPLY = 3'd4,
        ST_DISCARDED  = 3'd5
    } t_status;

    // Request class decided by the front part.
    typedef enum logic [1:0] {
        K_BYTE,
        K_READ,
        K_DISCARD,
        K_IGNORE
    } t_kind;

    // One input request.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    // One result.
    typedef struct packed {
        t_status     status;
        logic        overflowed;
        logic        line_complete;
        logic [7:0]  fill_count;
        logic [7:0]  text_length;
        logic [15:0] overflow_total;
        logic [7:0]  read_data;
    } t_out_item;

    // Classified request held in the queue.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_cmd;

    // Current configuration register contents.
    typedef struct packed {
        logic [63:0] token_bytes;
        logic [3:0]  token_length;
        logic [8:0]  line_capacity;
        logic        drop_null_bytes;
    } t_cfg;

    // Token length after clamping to TOKEN_MAX and cutting at the first null byte.
    function automatic logic [3:0] tok_len_eff(input logic [63:0] bytes,
                                               input logic [3:0]  length);
        logic [3:0] n;
        logic [3:0] len;
        logic       stop;
        n    = (length > 4'(TOKEN_MAX)) ? 4'(TOKEN_MAX) : length;
        len  = n;
        stop = 1'b0;
        for (int i = 0; i < TOKEN_MAX; i++) begin
            if (!stop && (4'(i) < n) && (bytes[8*i +: 8] == 8'h00)) begin
                len  = 4'(i);
                stop = 1'b1;
            end
        end
        return len;
    endfunction

endpackage

@@ sv/ttlc_front.sv @@
// ----------------------------------------------------------------------------
// ttlc_front: request intake and classification
// Accepts input requests, sorts them into byte, read, discard or ignored
// requests and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module ttlc_front
    import ttlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the incoming request.
    always_comb begin
        w_cmd.rx_byte    = i_in.rx_byte;
        w_cmd.read_index = i_in.read_index;
        case (i_in.req_type)
            REQ_BYTE:    w_cmd.kind = K_BYTE;
            REQ_READ:    w_cmd.kind = K_READ;
            REQ_DISCARD: w_cmd.kind = K_DISCARD;
            default:     w_cmd.kind = K_IGNORE;
        endcase
    end

    // Queue handshakes.
    assign o_in_ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

    // The fill count never goes beyond the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A pop without a push lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

@@ sv/ttlc_back.sv @@
// ----------------------------------------------------------------------------
// ttlc_back: request execution and result register
// Carries out one queued request per cycle unless the output stalls: appends
// bytes to the line store, tracks the token match, fill and overflow count,
// serves reads and discards, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module ttlc_back
    import ttlc_pkg::*;
#(
    parameter int LINE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int FW = $clog2(LINE_DEPTH);
    localparam int CW = (FW + 1 > 9) ? FW + 1 : 9;
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

    // Line store.
    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rd_hit;

    // Line state.
    logic [FW-1:0] r_fill, n_fill;
    logic [3:0]    r_match, n_match;
    logic          r_seen, n_seen;
    logic [15:0]   r_ovf_cnt, n_ovf_cnt;

    // Result register.
    logic          r_out_valid;
    t_out_item     r_out;

    logic          w_fire;
    logic [CW-1:0] w_cap_ext;
    logic [CW-1:0] w_cap;
    logic [FW-1:0] w_cap_m1;
    logic [3:0]    w_len;
    logic [3:0]    w_need;
    logic [7:0]    w_expect;
    logic [FW-1:0] w_base;
    logic          w_wr_en;
    logic          w_rd_hit;
    logic [CW-1:0] w_idx_ext;
    logic [FW-1:0] w_rd_addr;
    logic [CW-1:0] w_text_cur;
    logic [CW-1:0] w_fill_nx;
    logic [CW-1:0] w_match_nx;
    logic [CW-1:0] w_text_nx;
    t_status       w_status;
    logic          w_ovf;
    t_out_item     w_res;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_fire      = i_cmd_valid && o_cmd_ready;

    // Capacity clamp, token length and the byte expected next.
    always_comb begin
        w_cap_ext = CW'(i_cfg.line_capacity);
        if (w_cap_ext < CW'(2)) begin
            w_cap = CW'(2);
        end else if (w_cap_ext > DEPTH_C) begin
            w_cap = DEPTH_C;
        end else begin
            w_cap = w_cap_ext;
        end
        w_cap_m1 = FW'(w_cap - CW'(1));
        w_len    = tok_len_eff(i_cfg.token_bytes, i_cfg.token_length);
        w_need   = (w_len == 4'd0) ? 4'd1 : w_len;
        w_expect = (r_match < w_len) ? i_cfg.token_bytes[{r_match[2:0], 3'b000} +: 8] : 8'h00;
    end

    // Text length seen by a read, from the state before the request.
    always_comb begin
        if (r_seen) begin
            w_text_cur = (CW'(r_fill) >= CW'(r_match)) ? CW'(r_fill) - CW'(r_match) : '0;
        end else begin
            w_text_cur = CW'(r_fill);
        end
        w_idx_ext = CW'(i_cmd.read_index);
        w_rd_addr = w_idx_ext[FW-1:0];
    end

    // Request execution.
    always_comb begin
        n_fill    = r_fill;
        n_match   = r_match;
        n_seen    = r_seen;
        n_ovf_cnt = r_ovf_cnt;
        w_base    = r_fill;
        w_wr_en   = 1'b0;
        w_rd_hit  = 1'b0;
        w_ovf     = 1'b0;
        w_status  = ST_REFUSED;
        case (i_cmd.kind)
            K_BYTE: begin
                if (!r_seen) begin
                    // Overflow wipe before storing once the fill hits capacity minus one.
                    if (r_fill >= w_cap_m1) begin
                        w_ovf  = 1'b1;
                        w_base = '0;
                        if (r_ovf_cnt != 16'hFFFF) begin
                            n_ovf_cnt = r_ovf_cnt + 16'd1;
                        end
                    end
                    w_wr_en  = 1'b1;
                    n_fill   = w_base + 1'b1;
                    w_status = ST_STORED;
                    if (i_cmd.rx_byte != w_expect) begin
                        n_match = 4'd0;
                        if (i_cfg.drop_null_bytes && (i_cmd.rx_byte == 8'h00)) begin
                            n_fill   = '0;
                            w_status = ST_NULL_DROP;
                        end
                    end else begin
                        n_match = r_match + 4'd1;
                        if (n_match >= w_need) begin
                            n_seen   = 1'b1;
                            w_status = ST_TOKEN_DONE;
                        end
                    end
                end
            end
            K_READ: begin
                w_status = ST_READ_REPLY;
                w_rd_hit = (w_idx_ext < w_text_cur) && (w_idx_ext < DEPTH_C);
            end
            K_DISCARD: begin
                n_match  = 4'd0;
                n_fill   = '0;
                n_seen   = 1'b0;
                w_status = ST_DISCARDED;
            end
            default: begin
                w_status = ST_REFUSED;
            end
        endcase
    end

    // Result fields from the state after the request.
    always_comb begin
        w_fill_nx  = CW'(n_fill);
        w_match_nx = CW'(n_match);
        if (n_seen) begin
            w_text_nx = (w_fill_nx >= w_match_nx) ? w_fill_nx - w_match_nx : '0;
        end else begin
            w_text_nx = w_fill_nx;
        end
        w_res.status         = w_status;
        w_res.overflowed     = w_ovf;
        w_res.line_complete  = n_seen;
        w_res.fill_count     = w_fill_nx[7:0];
        w_res.text_length    = w_text_nx[7:0];
        w_res.overflow_total = n_ovf_cnt;
        w_res.read_data      = 8'h00;
    end

    // Line state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_match     <= '0;
            r_seen      <= 1'b0;
            r_ovf_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_fill    <= n_fill;
                r_match   <= n_match;
                r_seen    <= n_seen;
                r_ovf_cnt <= n_ovf_cnt;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line store access and result payload.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out    <= w_res;
            r_rd_hit <= w_rd_hit;
            if (w_wr_en) begin
                r_mem[w_base] <= i_cmd.rx_byte;
            end
            if (w_rd_hit) begin
                r_rd_data <= r_mem[w_rd_addr];
            end
        end
    end

    // Outputs, with the read data gated by the range check.
    assign o_out_valid = r_out_valid;
    always_comb begin
        o_out           = r_out;
        o_out.read_data = r_rd_hit ? r_rd_data : 8'h00;
    end

    // A completed line always holds a nonzero match count.
    a_seen_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_match != 4'd0))
        else $error("line complete with zero match count");

    // The overflow count never goes down.
    a_ovf_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_ovf_cnt >= $past(r_ovf_cnt)))
        else $error("overflow count decreased");

    // An executed read shows up as a read reply in the next cycle.
    a_read_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (i_cmd.kind == K_READ)) |=>
            (r_out_valid && (r_out.status == ST_READ_REPLY)))
        else $error("read request without read reply");

endmodule

@@ sv/token_terminated_line_capture.sv @@
// ----------------------------------------------------------------------------
// token_terminated_line_capture: line capture up to a terminator token
// Stores received bytes until the configured terminator token arrives and
// answers read-back and discard requests; holds the configuration registers.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in   (t_in_item)
//  out      output     o_out_valid / i_out_ready  o_out  (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each request produces exactly one result. A request leaves the two-entry
// front queue at the edge after its accept unless the back part is stalled,
// and its result is valid from that same edge. The back part executes one
// request per cycle while the output is not stalled, so requests can follow
// back to back.
// The line store has one write port and one registered read port.
// Reset (synchronous, active low) clears the line state, queue and result
// valid and restores the register defaults; the store itself is not cleared.
// A stalled output holds the result; the front keeps accepting until full.
// ----------------------------------------------------------------------------
module token_terminated_line_capture
    import ttlc_pkg::*;
#(
    parameter int LINE_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic [63:0] r_token_bytes;
    logic [3:0]  r_token_length;
    logic [8:0]  r_line_capacity;
    logic        r_null_clear;
    t_cfg        w_cfg;
    logic        w_cmd_valid;
    logic        w_cmd_ready;
    t_cmd        w_cmd;

    // Configuration registers are always ready to take a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_bytes   <= RST_TOKEN_BYTES;
            r_token_length  <= RST_TOKEN_LENGTH;
            r_line_capacity <= RST_LINE_CAPACITY;
            r_null_clear    <= RST_NULL_CLEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOKEN_BYTES:   r_token_bytes   <= i_cfg_data;
                CFG_TOKEN_LENGTH:  r_token_length  <= i_cfg_data[3:0];
                CFG_LINE_CAPACITY: r_line_capacity <= i_cfg_data[8:0];
                CFG_NULL_CLEAR:    r_null_clear    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Bundle the configuration for the back part.
    always_comb begin
        w_cfg.token_bytes     = r_token_bytes;
        w_cfg.token_length    = r_token_length;
        w_cfg.line_capacity   = r_line_capacity;
        w_cfg.drop_null_bytes = r_null_clear;
    end

    // Front part: intake, classification and queue.
    ttlc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Back part: execution, line store and result register.
    ttlc_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
